>>> rtl/lwpc_pkg.sv
// Shared types and constants of the LRU write-back page cache directory.
package lwpc_pkg;

	localparam int SLOT_W    = 4;
	localparam int WB_W      = 32;
	localparam int CAP_W     = 5;
	localparam int OP_W      = 2;
	localparam int OUT_DATA_W = 40;

	localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

	localparam logic [OP_W-1:0] OP_READ  = 2'd0;
	localparam logic [OP_W-1:0] OP_WRITE = 2'd1;
	localparam logic [OP_W-1:0] OP_FLUSH = 2'd2;
	localparam logic [OP_W-1:0] OP_NONE  = 2'd3;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SCAN,
		ST_HIT,
		ST_EV_RD,
		ST_EV_CHK,
		ST_INSERT,
		ST_FL_RD,
		ST_FL_CHK,
		ST_FL_NONE
	} state_t;

endpackage

>>> rtl/lru_writeback_page_cache.sv
// Top level: fully associative LRU write-back page cache directory.
// A hit scans the tags up to the matching slot; a miss scans every slot, evicts least
// recent pages as needed and then inserts. A flush walks the slots up to the last dirty
// one and waits on output stalls.
// One request at a time, bounded by the tag scan through the tag memory's read port.
// Reset (arst_n low, asynchronous): directory empty, no dirty pages, capacity 16.
module lru_writeback_page_cache
	import lwpc_pkg::*;
#(
	parameter int MAX_SLOTS        = 16,
	parameter int PAGE_NUMBER_BITS = 32
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// request: [1:0] opcode, [PAGE_NUMBER_BITS+1:2] page_number, zero pad above
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [((PAGE_NUMBER_BITS+2+7)/8)*8-1:0] s_tdata,
	// result: [0] hit, [4:1] slot, [5] fill_needed, [6] writeback_valid,
	// [38:7] writeback_page, [39] zero pad
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [OUT_DATA_W-1:0]       m_tdata,
	output logic                        m_tlast,
	// capacity register write
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [CAP_W-1:0]            cfg_data
);

	localparam int IDX_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
	localparam int CNT_W = $clog2(MAX_SLOTS + 1);
	localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_SLOTS - 1);

	// Directory state: tags in a synchronous memory, bookkeeping in flops.
	logic [PAGE_NUMBER_BITS-1:0] tag_mem [MAX_SLOTS];
	logic [PAGE_NUMBER_BITS-1:0] tag_rd_q;
	logic [IDX_W-1:0]            rd_addr;
	logic                        tag_we;
	logic [IDX_W-1:0]            wr_addr;

	logic [MAX_SLOTS-1:0] valid_q;
	logic [MAX_SLOTS-1:0] dirty_q;
	logic [IDX_W-1:0]     rank_q [MAX_SLOTS];
	logic [CNT_W-1:0]     count_q;
	logic [CAP_W-1:0]     cap_q;

	// Request being worked on
	state_t                      state_q, state_d;
	logic [OP_W-1:0]             op_q;
	logic [PAGE_NUMBER_BITS-1:0] page_q;
	logic [IDX_W-1:0]            idx_q;
	logic [IDX_W-1:0]            cmp_idx_s1;
	logic                        cmp_vld_s1;
	logic [IDX_W-1:0]            hit_slot_q;
	logic [IDX_W-1:0]            victim_q;
	logic                        evicted_q;
	logic                        ev_wbv_q;
	logic [PAGE_NUMBER_BITS-1:0] ev_wbp_q;

	// Output register
	logic            out_valid_q;
	logic            o_hit_q, o_fill_q, o_wbv_q, o_last_q;
	logic [SLOT_W-1:0] o_slot_q;
	logic [WB_W-1:0] o_wbp_q;

	// Result to load this cycle
	logic              emit;
	logic              e_hit, e_fill, e_wbv, e_last;
	logic [SLOT_W-1:0] e_slot;
	logic [WB_W-1:0]   e_wbp;
	logic              out_free;

	logic                  in_acc;
	logic [OP_W-1:0]       in_op;
	logic [PAGE_NUMBER_BITS-1:0] in_page;
	logic [CMP_W-1:0]      cap_eff;
	logic [CMP_W-1:0]      cnt_ext;
	logic                  tag_match;
	logic [IDX_W-1:0]      victim;
	logic [IDX_W-1:0]      free_slot;
	logic [IDX_W-1:0]      ins_slot;
	logic [MAX_SLOTS-1:0]  vd_vec;
	logic                  any_vd;
	logic                  more_vd;
	logic                  cur_vd;
	logic                  extra_ev;
	logic                  proceed;

	assign in_acc  = s_tvalid && s_tready;
	assign in_op   = s_tdata[OP_W-1:0];
	assign in_page = s_tdata[OP_W +: PAGE_NUMBER_BITS];
	assign cfg_ready = 1'b1;
	assign out_free  = !out_valid_q || m_tready;

	// Effective capacity: zero acts as one, anything above the slot count saturates.
	always_comb begin
		if (cap_q == '0) begin
			cap_eff = CMP_W'(1);
		end else if (CMP_W'(cap_q) > CMP_W'(MAX_SLOTS)) begin
			cap_eff = CMP_W'(MAX_SLOTS);
		end else begin
			cap_eff = CMP_W'(cap_q);
		end
	end
	assign cnt_ext  = CMP_W'(count_q);
	// More residents than capacity: this eviction is not the one the new page reuses.
	assign extra_ev = cnt_ext > cap_eff;

	assign tag_match = cmp_vld_s1 && valid_q[cmp_idx_s1] && (tag_rd_q == page_q);

	// Valid ranks form a permutation of 0..count-1, so the LRU page holds rank count-1.
	always_comb begin
		victim = '0;
		for (int j = MAX_SLOTS - 1; j >= 0; j--) begin
			if (valid_q[j] && rank_q[j] == IDX_W'(count_q - CNT_W'(1))) begin
				victim = IDX_W'(j);
			end
		end
	end

	// Lowest free slot for a fill without eviction
	always_comb begin
		free_slot = '0;
		for (int j = MAX_SLOTS - 1; j >= 0; j--) begin
			if (!valid_q[j]) begin
				free_slot = IDX_W'(j);
			end
		end
	end
	assign ins_slot = evicted_q ? victim_q : free_slot;

	// Flush walk: dirty residents and whether any lie above the current slot.
	assign vd_vec = valid_q & dirty_q;
	assign any_vd = |vd_vec;
	assign cur_vd = vd_vec[idx_q];
	always_comb begin
		more_vd = 1'b0;
		for (int j = 0; j < MAX_SLOTS; j++) begin
			if (vd_vec[j] && IDX_W'(j) > idx_q) begin
				more_vd = 1'b1;
			end
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					priority if (in_op == OP_NONE) begin
						state_d = ST_IDLE;
					end else if (in_op == OP_FLUSH) begin
						state_d = any_vd ? ST_FL_RD : ST_FL_NONE;
					end else begin
						state_d = ST_SCAN;
					end
				end
			end
			ST_SCAN: begin
				if (tag_match) begin
					state_d = ST_HIT;
				end else if (cmp_vld_s1 && cmp_idx_s1 == LAST_IDX) begin
					state_d = (cnt_ext >= cap_eff) ? ST_EV_RD : ST_INSERT;
				end
			end
			ST_HIT: begin
				if (out_free) state_d = ST_IDLE;
			end
			ST_EV_RD: begin
				state_d = ST_EV_CHK;
			end
			ST_EV_CHK: begin
				if (proceed) state_d = extra_ev ? ST_EV_RD : ST_INSERT;
			end
			ST_INSERT: begin
				if (out_free) state_d = ST_IDLE;
			end
			ST_FL_RD: begin
				state_d = ST_FL_CHK;
			end
			ST_FL_CHK: begin
				if (!cur_vd || out_free) state_d = more_vd ? ST_FL_RD : ST_IDLE;
			end
			ST_FL_NONE: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Outputs of the sequencer: memory port and result to load
	always_comb begin
		s_tready = 1'b0;
		rd_addr  = idx_q;
		tag_we   = 1'b0;
		wr_addr  = ins_slot;
		proceed  = 1'b0;
		emit     = 1'b0;
		e_hit    = 1'b0;
		e_fill   = 1'b0;
		e_wbv    = 1'b0;
		e_last   = 1'b0;
		e_slot   = '0;
		e_wbp    = '0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
			end
			ST_SCAN: begin
				rd_addr = idx_q;
			end
			ST_HIT: begin
				emit   = out_free;
				e_hit  = 1'b1;
				e_slot = SLOT_W'(hit_slot_q);
				e_last = 1'b1;
			end
			ST_EV_RD: begin
				rd_addr = victim;
			end
			ST_EV_CHK: begin
				// hold the victim tag on the read port while the result waits
				rd_addr = victim_q;
				proceed = !extra_ev || !dirty_q[victim_q] || out_free;
				if (extra_ev && dirty_q[victim_q]) begin
					emit   = out_free;
					e_wbv  = 1'b1;
					e_slot = SLOT_W'(victim_q);
					e_wbp  = WB_W'(tag_rd_q);
				end
			end
			ST_INSERT: begin
				tag_we = out_free;
				emit   = out_free;
				e_fill = 1'b1;
				e_slot = SLOT_W'(ins_slot);
				e_wbv  = ev_wbv_q;
				e_wbp  = WB_W'(ev_wbp_q);
				e_last = 1'b1;
			end
			ST_FL_RD: begin
				rd_addr = idx_q;
			end
			ST_FL_CHK: begin
				if (cur_vd) begin
					emit   = out_free;
					e_wbv  = 1'b1;
					e_slot = SLOT_W'(idx_q);
					e_wbp  = WB_W'(tag_rd_q);
					e_last = !more_vd;
				end
			end
			ST_FL_NONE: begin
				emit   = out_free;
				e_last = 1'b1;
			end
			default: begin
				s_tready = 1'b0;
			end
		endcase
	end

	// Tag memory: one read and one write port, registered read data.
	always_ff @(posedge clk) begin
		if (tag_we) begin
			tag_mem[wr_addr] <= page_q;
		end
		tag_rd_q <= tag_mem[rd_addr];
	end

	// Request payload and walk registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			op_q   <= in_op;
			page_q <= in_page;
		end
		if (state_q == ST_SCAN && tag_match) begin
			hit_slot_q <= cmp_idx_s1;
		end
		if (state_q == ST_EV_RD) begin
			victim_q <= victim;
		end
		if (state_q == ST_EV_CHK && proceed && !extra_ev) begin
			// final eviction: the new page reuses this slot
			ev_wbv_q <= dirty_q[victim_q];
			ev_wbp_q <= dirty_q[victim_q] ? tag_rd_q : '0;
		end else if (in_acc) begin
			ev_wbv_q <= 1'b0;
			ev_wbp_q <= '0;
		end
		if (state_q == ST_SCAN) begin
			cmp_idx_s1 <= idx_q;
		end
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			idx_q      <= '0;
			cmp_vld_s1 <= 1'b0;
			evicted_q  <= 1'b0;
			cap_q      <= CAP_RESET;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				cap_q <= cfg_data;
			end
			// scan issues one tag read per cycle; the compare works on the registered read data and index
			cmp_vld_s1 <= (state_q == ST_SCAN) && (state_d == ST_SCAN);
			if (in_acc) begin
				idx_q     <= '0;
				evicted_q <= 1'b0;
			end else if (state_q == ST_SCAN) begin
				idx_q <= idx_q + IDX_W'(1);
			end else if (state_q == ST_FL_CHK && state_d == ST_FL_RD) begin
				idx_q <= idx_q + IDX_W'(1);
			end
			if (state_q == ST_EV_CHK && proceed && !extra_ev) begin
				evicted_q <= 1'b1;
			end
		end
	end

	// Directory bookkeeping: valid, dirty, recency ranks, resident count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			dirty_q <= '0;
			count_q <= '0;
			for (int j = 0; j < MAX_SLOTS; j++) begin
				rank_q[j] <= '0;
			end
		end else begin
			unique case (state_q)
				ST_HIT: begin
					if (out_free) begin
						// promote the hit page, age the ones that were more recent
						for (int j = 0; j < MAX_SLOTS; j++) begin
							if (valid_q[j] && rank_q[j] < rank_q[hit_slot_q]) begin
								rank_q[j] <= rank_q[j] + IDX_W'(1);
							end
						end
						rank_q[hit_slot_q] <= '0;
						if (op_q == OP_WRITE) begin
							dirty_q[hit_slot_q] <= 1'b1;
						end
					end
				end
				ST_EV_CHK: begin
					if (proceed) begin
						valid_q[victim_q] <= 1'b0;
						dirty_q[victim_q] <= 1'b0;
						rank_q[victim_q]  <= '0;
						count_q           <= count_q - CNT_W'(1);
					end
				end
				ST_INSERT: begin
					if (out_free) begin
						for (int j = 0; j < MAX_SLOTS; j++) begin
							if (valid_q[j]) begin
								rank_q[j] <= rank_q[j] + IDX_W'(1);
							end
						end
						valid_q[ins_slot] <= 1'b1;
						dirty_q[ins_slot] <= (op_q == OP_WRITE);
						rank_q[ins_slot]  <= '0;
						count_q           <= count_q + CNT_W'(1);
					end
				end
				ST_FL_CHK: begin
					if (cur_vd && out_free) begin
						dirty_q[idx_q] <= 1'b0;
					end
				end
				default: begin
					count_q <= count_q;
				end
			endcase
		end
	end

	// Output register: loads when empty or being drained.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			o_hit_q  <= e_hit;
			o_slot_q <= e_slot;
			o_fill_q <= e_fill;
			o_wbv_q  <= e_wbv;
			o_wbp_q  <= e_wbp;
			o_last_q <= e_last;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {1'b0, o_wbp_q, o_wbv_q, o_fill_q, o_slot_q, o_hit_q};
	assign m_tlast  = o_last_q;

	// Resident count tracks the valid bits.
	a_count_matches: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(valid_q) == int'(count_q))
		else $error("resident count out of step with valid bits");

	// A fill always lands below the effective capacity.
	a_insert_room: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_INSERT |-> cnt_ext < cap_eff)
		else $error("insert with no free slot under capacity");

	// A hit names a resident slot.
	a_hit_valid: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_HIT |-> valid_q[hit_slot_q])
		else $error("hit slot not resident");

	// A fill without eviction takes a free slot.
	a_insert_free: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_INSERT && !evicted_q) |-> !valid_q[free_slot])
		else $error("fill target slot already occupied");

endmodule

>>> dv/lwpc_checker.sv
`timescale 1ns / 100ps
// Checker: predicts page cache directory results and compares them with the block.
module lwpc_checker
	import lwpc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [39:0] s_tdata,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [39:0] m_tdata,
	input  logic        m_tlast,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [4:0]  cfg_data,
	output int          fail_count,
	output int          pending
);
	localparam int NSLOT = 16;

	typedef struct packed {
		logic        hit;
		logic [3:0]  slot;
		logic        fill;
		logic        wbv;
		logic [31:0] wbp;
		logic        last;
	} lookup_t;

	logic [31:0] tag_q [NSLOT];
	logic        valid_q [NSLOT];
	logic        dirty_q [NSLOT];
	int          rank_q [NSLOT];
	int          resident;
	logic [4:0]  capacity;
	lookup_t     expected_q [$];

	assign pending = expected_q.size();

	function automatic lookup_t mk(logic h, int s, logic f, logic v, logic [31:0] p,
			logic l);
		lookup_t r;
		r.hit = h; r.slot = s[3:0]; r.fill = f; r.wbv = v; r.wbp = p; r.last = l;
		return r;
	endfunction

	task automatic predict_request(logic [1:0] op, logic [31:0] page);
		int i, cap, slot, n, v, r, found;
		logic wbv, evicted;
		logic [31:0] wbp;
		n = 0; slot = 0; found = 0; wbv = 0; evicted = 0; wbp = '0;
		if (op == OP_NONE)
			return;
		if (op == OP_FLUSH) begin
			for (i = 0; i < NSLOT; i++)
				if (valid_q[i] && dirty_q[i]) begin
					dirty_q[i] = 0;
					expected_q.push_back(mk(0, i, 0, 1, tag_q[i], 0));
					n++;
				end
			if (n == 0)
				expected_q.push_back(mk(0, 0, 0, 0, '0, 1));
			else
				expected_q[$].last = 1;
			return;
		end
		for (i = 0; i < NSLOT; i++)
			if (!found && valid_q[i] && tag_q[i] == page) begin
				slot = i;
				found = 1;
			end
		if (found) begin
			r = rank_q[slot];
			for (i = 0; i < NSLOT; i++)
				if (valid_q[i] && rank_q[i] < r)
					rank_q[i]++;
			rank_q[slot] = 0;
			if (op == OP_WRITE)
				dirty_q[slot] = 1;
			expected_q.push_back(mk(1, slot, 0, 0, '0, 1));
			return;
		end
		cap = (capacity < 1) ? 1 : (capacity > NSLOT) ? NSLOT : capacity;
		// evict least recent pages until one slot is free under the capacity
		while (resident >= cap) begin
			v = -1;
			for (i = 0; i < NSLOT; i++)
				if (valid_q[i] && (v < 0 || rank_q[i] > rank_q[v]))
					v = i;
			if (resident - 1 >= cap) begin
				if (dirty_q[v])
					expected_q.push_back(mk(0, v, 0, 1, tag_q[v], 0));
			end else begin
				wbv = dirty_q[v];
				wbp = dirty_q[v] ? tag_q[v] : '0;
				slot = v;
				evicted = 1;
			end
			valid_q[v] = 0; dirty_q[v] = 0; rank_q[v] = 0;
			resident--;
		end
		if (!evicted)
			for (i = NSLOT - 1; i >= 0; i--)
				if (!valid_q[i])
					slot = i;
		for (i = 0; i < NSLOT; i++)
			if (valid_q[i])
				rank_q[i]++;
		valid_q[slot] = 1;
		tag_q[slot] = page;
		dirty_q[slot] = (op == OP_WRITE);
		rank_q[slot] = 0;
		resident++;
		expected_q.push_back(mk(0, slot, 1, wbv, wbp, 1));
	endtask

	task automatic compare_result(lookup_t exp, lookup_t act);
		if (act.hit !== exp.hit) begin
			$error("hit: expected %0d, got %0d", exp.hit, act.hit);
			fail_count++;
		end
		if (act.slot !== exp.slot) begin
			$error("slot: expected %0d, got %0d", exp.slot, act.slot);
			fail_count++;
		end
		if (act.fill !== exp.fill) begin
			$error("fill_needed: expected %0d, got %0d", exp.fill, act.fill);
			fail_count++;
		end
		if (act.wbv !== exp.wbv) begin
			$error("writeback_valid: expected %0d, got %0d", exp.wbv, act.wbv);
			fail_count++;
		end
		if (act.wbp !== exp.wbp) begin
			$error("writeback_page: expected %h, got %h", exp.wbp, act.wbp);
			fail_count++;
		end
		if (act.last !== exp.last) begin
			$error("last: expected %0d, got %0d", exp.last, act.last);
			fail_count++;
		end
	endtask

	initial fail_count = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NSLOT; i++) begin
				valid_q[i] = 0; dirty_q[i] = 0; rank_q[i] = 0; tag_q[i] = '0;
			end
			resident = 0;
			capacity = CAP_RESET;
			expected_q.delete();
		end else begin
			if (cfg_valid && cfg_ready)
				capacity = cfg_data;
			if (m_tvalid && m_tready) begin
				if (expected_q.size() == 0) begin
					$error("unexpected result %h last %0d", m_tdata, m_tlast);
					fail_count++;
				end else
					compare_result(expected_q.pop_front(),
						mk(m_tdata[0], m_tdata[4:1], m_tdata[5], m_tdata[6],
							m_tdata[38:7], m_tlast));
			end
			if (s_tvalid && s_tready)
				predict_request(s_tdata[1:0], s_tdata[33:2]);
		end
	end
endmodule

>>> dv/tb_top.sv
`timescale 1ns / 100ps
// Testbench top: drives requests and capacity writes, stalls results, gives the verdict.
module tb_top;
	import lwpc_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid, s_tready;
	logic [39:0] s_tdata;
	logic        m_tvalid, m_tready, m_tlast;
	logic [39:0] m_tdata;
	logic        cfg_valid, cfg_ready;
	logic [4:0]  cfg_data;
	int          fail_count, pending;

	lru_writeback_page_cache uut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	lwpc_checker chk (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.fail_count(fail_count), .pending(pending)
	);

	// 4 ns clock
	initial clk = 0;
	always begin
		#2 clk = 1;
		#2 clk = 0;
	end

	// pick a gap length: mostly none or short, now and then long
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// random result stall, with stall-free stretches switched by the phase flag
	logic stall_free;
	always @(posedge clk) begin
		if ($urandom_range(0, 199) == 0)
			stall_free <= ~stall_free;
		m_tready <= stall_free ? 1'b1 : ($urandom_range(0, 99) < 65);
	end

	// drop valid only for a gap, otherwise present the next request right away
	task automatic send_request(logic [1:0] op, logic [31:0] page);
		int g;
		g = stall_free ? 0 : gap_len();
		if (g != 0) begin
			s_tvalid <= 0;
			repeat (g) @(posedge clk);
		end
		s_tvalid <= 1;
		s_tdata  <= {6'd0, page, op};
		do @(posedge clk); while (!s_tready);
	endtask

	// hold off new requests until every expected result has come
	task automatic wait_results();
		s_tvalid <= 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	// drain outstanding results, then give the block time to finish silent work
	task automatic drain();
		wait_results();
		repeat (80) @(posedge clk);
	endtask

	task automatic write_capacity(logic [4:0] value);
		drain();
		cfg_valid <= 1;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 0;
	endtask

	// pages from a small pool so hits and evictions both happen often
	function automatic logic [31:0] pick_page();
		int r;
		r = $urandom_range(0, 9);
		if (r < 8) return $urandom_range(0, 23);
		return $urandom();
	endfunction

	function automatic logic [1:0] pick_op();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45) return OP_READ;
		if (r < 88) return OP_WRITE;
		if (r < 96) return OP_FLUSH;
		return OP_NONE;
	endfunction

	initial begin
		logic [4:0] caps [6];
		s_tvalid = 0; s_tdata = '0; cfg_valid = 0; cfg_data = '0;
		m_tready = 0; stall_free = 0;
		arst_n = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: empty flush, extremes of page numbers, hits, dirty flush, ignored op
		send_request(OP_FLUSH, 32'h0);
		send_request(OP_READ, 32'h0);
		send_request(OP_WRITE, 32'hFFFF_FFFF);
		send_request(OP_READ, 32'hFFFF_FFFF);
		send_request(OP_WRITE, 32'h0);
		send_request(OP_NONE, 32'hA5A5_5A5A);
		send_request(OP_WRITE, 32'h5555_AAAA);
		send_request(OP_READ, 32'hAAAA_5555);
		send_request(OP_FLUSH, 32'hFFFF_FFFF);
		send_request(OP_FLUSH, 32'h0);
		// fill the remaining slots with writes until all 16 are resident
		for (int i = 0; i < 12; i++)
			send_request(OP_WRITE, 32'h100 + i);
		// lower capacity under occupancy: a miss evicts several pages
		write_capacity(5'd3);
		send_request(OP_READ, 32'h200);
		write_capacity(5'd0);
		send_request(OP_WRITE, 32'h201);
		send_request(OP_READ, 32'h202);
		write_capacity(5'd31);

		// random phases over several capacity settings
		caps = '{5'd1, 5'd16, 5'd4, 5'd0, 5'd20, 5'd8};
		for (int ph = 0; ph < 6; ph++) begin
			write_capacity(ph == 5 ? 5'($urandom_range(0, 31)) : caps[ph]);
			for (int k = 0; k < 40; k++) begin
				if (ph == 2 && k == 20)
					wait_results();
				send_request(pick_op(), pick_page());
			end
		end
		drain();
		if (fail_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		#4_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end
endmodule

>>> filelist.f
rtl/lwpc_pkg.sv
rtl/lru_writeback_page_cache.sv
dv/lwpc_checker.sv
dv/tb_top.sv
